[rtl/fmbq_pkg.sv]
// ---------------------------------------------------------------------------
// fmbq_pkg: shared types and helpers of the front/middle/back queue
// Sizes, command and status codes, beat structs and ring index arithmetic.
// ---------------------------------------------------------------------------
`default_nettype none

package fmbq_pkg;

  // sizing
  localparam int unsigned CAPACITY   = 1024;
  localparam int unsigned DATA_WIDTH = 32;
  localparam int unsigned RING_DEPTH = (CAPACITY + 1) / 2;
  localparam int unsigned IDX_W      = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int unsigned CNT_W      = $clog2(RING_DEPTH + 1);
  localparam int unsigned SUM_W      = CNT_W + 1;

  // fixed field widths
  localparam int unsigned CMD_W    = 3;
  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned OCC_W    = 11;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH_FRONT = 3'd0,
    CMD_PUSH_MID   = 3'd1,
    CMD_PUSH_BACK  = 3'd2,
    CMD_POP_FRONT  = 3'd3,
    CMD_POP_MID    = 3'd4,
    CMD_POP_BACK   = 3'd5
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_DONE  = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_FULL  = 2'd2
  } status_e;

  typedef struct packed {
    logic [CMD_W-1:0]          command;
    logic signed [VALUE_W-1:0] item_value;
  } in_beat_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] result_value;
    logic [STATUS_W-1:0]       status;
    logic [OCC_W-1:0]          occupancy;
  } out_beat_t;

  // ring index helpers, all results wrap modulo RING_DEPTH
  function automatic logic [IDX_W-1:0] ring_inc(input logic [IDX_W-1:0] a);
    logic [IDX_W-1:0] r;
    r = (a == IDX_W'(RING_DEPTH - 1)) ? '0 : a + 1'b1;
    return r;
  endfunction

  function automatic logic [IDX_W-1:0] ring_dec(input logic [IDX_W-1:0] a);
    logic [IDX_W-1:0] r;
    r = (a == '0) ? IDX_W'(RING_DEPTH - 1) : a - 1'b1;
    return r;
  endfunction

  // a below RING_DEPTH, b at most RING_DEPTH
  function automatic logic [IDX_W-1:0] ring_add(input logic [IDX_W-1:0] a,
                                                 input logic [CNT_W-1:0] b);
    logic [SUM_W:0] s;
    s = (SUM_W + 1)'(a) + (SUM_W + 1)'(b);
    if (s >= (SUM_W + 1)'(RING_DEPTH)) begin
      s = s - (SUM_W + 1)'(RING_DEPTH);
    end
    return IDX_W'(s);
  endfunction

endpackage

`default_nettype wire

[rtl/fmbq_ram.sv]
// ---------------------------------------------------------------------------
// fmbq_ram: generic simple dual-port ram
// One write port, one read port with registered read data.
// ---------------------------------------------------------------------------
`default_nettype none

module fmbq_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 512
) (
  input  wire logic                                        clk_i,
  input  wire logic                                        wr_en_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr_i,
  input  wire logic [WIDTH-1:0]                            wr_data_i,
  input  wire logic                                        rd_en_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr_i,
  output logic      [WIDTH-1:0]                            rd_data_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_o <= mem[rd_addr_i];
    end
  end

endmodule

`default_nettype wire

[rtl/front_middle_back_queue_unit.sv]
// ---------------------------------------------------------------------------
// front_middle_back_queue_unit: queue with push and pop at front, middle, back
// Two ring halves in block ram, rebalanced after every operation.
// ---------------------------------------------------------------------------
// channel   direction  handshake                  payload
// in        input      in_valid_i / in_stall_o    in_i  (command, item_value)
// out       output     out_valid_o / out_stall_i  out_o (result_value, status, occupancy)
//
// every operation has an accept cycle, which issues one read to each half
// ram, and a write-back cycle, which writes back at most one entry per half,
// moves the head and count registers and loads the output register.
// the output register lets a new beat in while a result still waits; the
// write-back cycle holds until that register is free.
// reset clears heads, counts and control; the rams need no clearing pass.
// ---------------------------------------------------------------------------
`default_nettype none

module front_middle_back_queue_unit (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire fmbq_pkg::in_beat_t in_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output fmbq_pkg::out_beat_t     out_o
);

  localparam int unsigned IDX_W = fmbq_pkg::IDX_W;
  localparam int unsigned CNT_W = fmbq_pkg::CNT_W;
  localparam int unsigned SUM_W = fmbq_pkg::SUM_W;
  localparam int unsigned DW    = fmbq_pkg::DATA_WIDTH;
  localparam int unsigned VALUE_W_LOCAL = fmbq_pkg::VALUE_W;

  // sequencer states
  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic [0:0] state_q, state_d;

  // ring pointers of the front and back halves
  logic [IDX_W-1:0] fh_head_q, fh_head_d, bh_head_q, bh_head_d;
  logic [CNT_W-1:0] fh_cnt_q, fh_cnt_d, bh_cnt_q, bh_cnt_d;

  // captured beat
  logic [fmbq_pkg::CMD_W-1:0] cmd_q;
  logic [DW-1:0]              val_q;

  // output register
  logic                out_valid_q, out_valid_d;
  fmbq_pkg::out_beat_t out_q, out_d;

  // ram ports
  logic             fh_we, bh_we;
  logic [IDX_W-1:0] fh_waddr, bh_waddr, fh_raddr, bh_raddr;
  logic [DW-1:0]    fh_wdata, bh_wdata, fh_rdata, bh_rdata;

  logic accept, commit;
  logic [IDX_W-1:0] fh_tail, bh_tail;
  logic [SUM_W-1:0] total;
  logic full, empty;

  assign in_stall_o  = (state_q != S_IDLE);
  assign accept      = in_valid_i && (state_q == S_IDLE);
  assign commit      = (state_q == S_EXEC) && (!out_valid_q || !out_stall_i);
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  // last held entry of each half
  assign fh_tail = fmbq_pkg::ring_dec(fmbq_pkg::ring_add(fh_head_q, fh_cnt_q));
  assign bh_tail = fmbq_pkg::ring_dec(fmbq_pkg::ring_add(bh_head_q, bh_cnt_q));

  // read side: front pop reads the front half head, all else its tail;
  // back pop reads the back half tail, all else its head
  always_comb begin
    fh_raddr = (fmbq_pkg::cmd_e'(in_i.command) == fmbq_pkg::CMD_POP_FRONT) ?
               fh_head_q : fh_tail;
    bh_raddr = (fmbq_pkg::cmd_e'(in_i.command) == fmbq_pkg::CMD_POP_BACK) ?
               bh_tail : bh_head_q;
  end

  fmbq_ram #(
    .WIDTH (DW),
    .DEPTH (fmbq_pkg::RING_DEPTH)
  ) u_front_ram (
    .clk_i     (clk_i),
    .wr_en_i   (fh_we),
    .wr_addr_i (fh_waddr),
    .wr_data_i (fh_wdata),
    .rd_en_i   (accept),
    .rd_addr_i (fh_raddr),
    .rd_data_o (fh_rdata)
  );

  fmbq_ram #(
    .WIDTH (DW),
    .DEPTH (fmbq_pkg::RING_DEPTH)
  ) u_back_ram (
    .clk_i     (clk_i),
    .wr_en_i   (bh_we),
    .wr_addr_i (bh_waddr),
    .wr_data_i (bh_wdata),
    .rd_en_i   (accept),
    .rd_addr_i (bh_raddr),
    .rd_data_o (bh_rdata)
  );

  assign total = SUM_W'(fh_cnt_q) + SUM_W'(bh_cnt_q);
  assign full  = (total >= SUM_W'(fmbq_pkg::CAPACITY));
  // back half is never shorter than the front, so it is empty only with the queue
  assign empty = (bh_cnt_q == '0);

  // write-back: modify and rebalance
  always_comb begin
    logic [VALUE_W_LOCAL-1:0] res;
    fmbq_pkg::status_e        st;
    fh_we     = 1'b0;
    bh_we     = 1'b0;
    fh_waddr  = fmbq_pkg::ring_dec(fh_head_q);
    bh_waddr  = fmbq_pkg::ring_dec(bh_head_q);
    fh_wdata  = val_q;
    bh_wdata  = val_q;
    fh_head_d = fh_head_q;
    bh_head_d = bh_head_q;
    fh_cnt_d  = fh_cnt_q;
    bh_cnt_d  = bh_cnt_q;
    res       = '0;
    st        = fmbq_pkg::STATUS_DONE;

    unique case (fmbq_pkg::cmd_e'(cmd_q))
      fmbq_pkg::CMD_PUSH_FRONT: begin
        if (full) begin
          st = fmbq_pkg::STATUS_FULL;
        end else if (fh_cnt_q == bh_cnt_q) begin
          // new front entry, front tail crosses over to the back half
          fh_we     = 1'b1;
          fh_head_d = fmbq_pkg::ring_dec(fh_head_q);
          bh_we     = 1'b1;
          bh_wdata  = (fh_cnt_q == '0) ? val_q : fh_rdata;
          bh_head_d = fmbq_pkg::ring_dec(bh_head_q);
          bh_cnt_d  = bh_cnt_q + 1'b1;
        end else begin
          fh_we     = 1'b1;
          fh_head_d = fmbq_pkg::ring_dec(fh_head_q);
          fh_cnt_d  = fh_cnt_q + 1'b1;
        end
      end
      fmbq_pkg::CMD_PUSH_MID: begin
        if (full) begin
          st = fmbq_pkg::STATUS_FULL;
        end else if (fh_cnt_q == bh_cnt_q) begin
          bh_we     = 1'b1;
          bh_head_d = fmbq_pkg::ring_dec(bh_head_q);
          bh_cnt_d  = bh_cnt_q + 1'b1;
        end else begin
          fh_we    = 1'b1;
          fh_waddr = fmbq_pkg::ring_add(fh_head_q, fh_cnt_q);
          fh_cnt_d = fh_cnt_q + 1'b1;
        end
      end
      fmbq_pkg::CMD_PUSH_BACK: begin
        bh_waddr = fmbq_pkg::ring_add(bh_head_q, bh_cnt_q);
        if (full) begin
          st = fmbq_pkg::STATUS_FULL;
        end else if (bh_cnt_q > fh_cnt_q) begin
          // back head crosses over to the front tail, count of back half holds
          fh_we     = 1'b1;
          fh_waddr  = fmbq_pkg::ring_add(fh_head_q, fh_cnt_q);
          fh_wdata  = bh_rdata;
          fh_cnt_d  = fh_cnt_q + 1'b1;
          bh_we     = 1'b1;
          bh_head_d = fmbq_pkg::ring_inc(bh_head_q);
        end else begin
          bh_we    = 1'b1;
          bh_cnt_d = bh_cnt_q + 1'b1;
        end
      end
      fmbq_pkg::CMD_POP_FRONT: begin
        if (empty) begin
          res = '1;
          st  = fmbq_pkg::STATUS_EMPTY;
        end else if (fh_cnt_q == '0) begin
          res       = VALUE_W_LOCAL'(bh_rdata);
          bh_head_d = fmbq_pkg::ring_inc(bh_head_q);
          bh_cnt_d  = bh_cnt_q - 1'b1;
        end else begin
          res       = VALUE_W_LOCAL'(fh_rdata);
          fh_head_d = fmbq_pkg::ring_inc(fh_head_q);
          if (bh_cnt_q > fh_cnt_q) begin
            fh_we     = 1'b1;
            fh_waddr  = fmbq_pkg::ring_add(fh_head_q, fh_cnt_q);
            fh_wdata  = bh_rdata;
            bh_head_d = fmbq_pkg::ring_inc(bh_head_q);
            bh_cnt_d  = bh_cnt_q - 1'b1;
          end else begin
            fh_cnt_d = fh_cnt_q - 1'b1;
          end
        end
      end
      fmbq_pkg::CMD_POP_MID: begin
        if (empty) begin
          res = '1;
          st  = fmbq_pkg::STATUS_EMPTY;
        end else if (fh_cnt_q == bh_cnt_q) begin
          res      = VALUE_W_LOCAL'(fh_rdata);
          fh_cnt_d = fh_cnt_q - 1'b1;
        end else begin
          res       = VALUE_W_LOCAL'(bh_rdata);
          bh_head_d = fmbq_pkg::ring_inc(bh_head_q);
          bh_cnt_d  = bh_cnt_q - 1'b1;
        end
      end
      fmbq_pkg::CMD_POP_BACK: begin
        if (empty) begin
          res = '1;
          st  = fmbq_pkg::STATUS_EMPTY;
        end else begin
          res = VALUE_W_LOCAL'(bh_rdata);
          if (bh_cnt_q == fh_cnt_q) begin
            // front tail crosses over to the back head
            bh_we     = 1'b1;
            bh_wdata  = fh_rdata;
            bh_head_d = fmbq_pkg::ring_dec(bh_head_q);
            fh_cnt_d  = fh_cnt_q - 1'b1;
          end else begin
            bh_cnt_d = bh_cnt_q - 1'b1;
          end
        end
      end
      default: begin
        // unknown command: no change, plain done beat
      end
    endcase

    if (!commit) begin
      fh_we     = 1'b0;
      bh_we     = 1'b0;
      fh_head_d = fh_head_q;
      bh_head_d = bh_head_q;
      fh_cnt_d  = fh_cnt_q;
      bh_cnt_d  = bh_cnt_q;
    end

    out_d.result_value = res;
    out_d.status       = st;
    out_d.occupancy    = fmbq_pkg::OCC_W'(SUM_W'(fh_cnt_d) + SUM_W'(bh_cnt_d));
  end

  // sequencer and output valid
  always_comb begin
    state_d = state_q;
    if (accept) begin
      state_d = S_EXEC;
    end else if (commit) begin
      state_d = S_IDLE;
    end
    out_valid_d = commit ? 1'b1 : (out_valid_q && out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      fh_head_q   <= '0;
      bh_head_q   <= '0;
      fh_cnt_q    <= '0;
      bh_cnt_q    <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      fh_head_q   <= fh_head_d;
      bh_head_q   <= bh_head_d;
      fh_cnt_q    <= fh_cnt_d;
      bh_cnt_q    <= bh_cnt_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q <= in_i.command;
      val_q <= DW'($unsigned(in_i.item_value));
    end
    if (commit) begin
      out_q <= out_d;
    end
  end

  // the back half holds as many entries as the front half or one more
  a_balance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (bh_cnt_q == fh_cnt_q) || (bh_cnt_q == fh_cnt_q + 1'b1))
    else $error("queue halves out of balance");

  // occupancy never exceeds the capacity
  a_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    total <= SUM_W'(fmbq_pkg::CAPACITY))
    else $error("queue holds more than its capacity");

  // an accepted beat always enters the write-back cycle next
  a_accept_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == S_EXEC))
    else $error("accepted beat not executed");

  // a result appears only after a write-back cycle
  a_result_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_EXEC))
    else $error("result without operation");

  // a write-back held by a stalled output leaves the pointers alone
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_EXEC) && out_valid_q && out_stall_i) |=>
      ($stable(fh_cnt_q) && $stable(bh_cnt_q) && $stable(fh_head_q) && $stable(bh_head_q)))
    else $error("queue state moved while output stalled");

endmodule

`default_nettype wire

[tb/front_middle_back_queue_unit_test.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// front_middle_back_queue_unit_test: self-checking bench for the fmb queue
// Walks a short table of hand-picked operations, then long random runs that
// fill the queue to capacity and drain it past empty. Every result beat is
// checked field by field against a typed row or a behavioural ring-half model.
// ---------------------------------------------------------------------------

module front_middle_back_queue_unit_test;

  localparam int unsigned CMD_W      = fmbq_pkg::CMD_W;
  localparam int unsigned VALUE_W    = fmbq_pkg::VALUE_W;
  localparam int unsigned OCC_W      = fmbq_pkg::OCC_W;
  localparam int unsigned DATA_WIDTH = fmbq_pkg::DATA_WIDTH;
  localparam int unsigned CAPACITY   = fmbq_pkg::CAPACITY;

  localparam int unsigned HALF_SLOTS      = fmbq_pkg::RING_DEPTH;
  localparam int unsigned FRONT_HALF      = 0;
  localparam int unsigned BACK_HALF       = 1;
  localparam int unsigned HOLD_OFF_AT     = 600;   // beats in before the long hold-off
  localparam int unsigned HOLD_OFF_CYCLES = 400;
  localparam int unsigned QUIET_LIMIT     = 5000;  // cycles with no beat on either side
  localparam int unsigned DRAIN_CYCLES    = 20;
  localparam int unsigned SCRIPT_ROWS     = 23;

  // command codes the block does not decode, it must answer them as no-ops
  localparam logic [CMD_W-1:0] CMD_SPARE_A = 3'd6;
  localparam logic [CMD_W-1:0] CMD_SPARE_B = 3'd7;

  localparam logic [VALUE_W-1:0] ALL_ONES  = '1;
  localparam logic [VALUE_W-1:0] KEEP_MASK = VALUE_W'((65'd1 << DATA_WIDTH) - 65'd1);

  typedef enum int unsigned {
    FLOW_OPEN,
    FLOW_COIN,
    FLOW_PERIODIC,
    FLOW_CHOKED
  } flow_e;

  typedef struct {
    logic [CMD_W-1:0]   command;
    logic [VALUE_W-1:0] value;
    bit                 typed;        // expected result written out in the row
    logic [VALUE_W-1:0] want_value;
    fmbq_pkg::status_e  want_status;
    int unsigned        want_occ;
  } script_row_t;

  // ---------------------------------------------------------------------------
  // clock, reset and the block
  // ---------------------------------------------------------------------------
  logic                clk       = 1'b0;
  logic                rst_n     = 1'b0;
  logic                in_valid  = 1'b0;
  logic                in_stall;
  fmbq_pkg::in_beat_t  in_beat   = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  fmbq_pkg::out_beat_t out_beat;

  always #2 clk = ~clk;

  front_middle_back_queue_unit u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_i        (in_beat),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_o       (out_beat)
  );

  // ---------------------------------------------------------------------------
  // queue model: two ring halves, the back half holds as many or one more
  // ---------------------------------------------------------------------------
  logic [VALUE_W-1:0] half_ring  [2][HALF_SLOTS];
  int unsigned        half_head  [2] = '{default: 0};
  int unsigned        half_count [2] = '{default: 0};

  fmbq_pkg::out_beat_t awaited_outcomes [$];
  int unsigned beats_accepted = 0;
  int unsigned burst_left     = 20;
  bit          holding_off    = 1'b0;
  int unsigned fail_count     = 0;
  int unsigned quiet_cycles   = 0;

  function automatic int unsigned queue_occupancy();
    return half_count[FRONT_HALF] + half_count[BACK_HALF];
  endfunction

  function automatic void half_put_first(int unsigned h, logic [VALUE_W-1:0] v);
    if (half_count[h] >= HALF_SLOTS) return;
    half_head[h] = (half_head[h] == 0) ? HALF_SLOTS - 1 : half_head[h] - 1;
    half_ring[h][half_head[h]] = v;
    half_count[h]++;
  endfunction

  function automatic void half_put_last(int unsigned h, logic [VALUE_W-1:0] v);
    if (half_count[h] >= HALF_SLOTS) return;
    half_ring[h][(half_head[h] + half_count[h]) % HALF_SLOTS] = v;
    half_count[h]++;
  endfunction

  function automatic logic [VALUE_W-1:0] half_take_first(int unsigned h);
    logic [VALUE_W-1:0] v;
    if (half_count[h] == 0) return '0;
    v = half_ring[h][half_head[h]];
    half_head[h] = (half_head[h] + 1) % HALF_SLOTS;
    half_count[h]--;
    return v;
  endfunction

  function automatic logic [VALUE_W-1:0] half_take_last(int unsigned h);
    if (half_count[h] == 0) return '0;
    half_count[h]--;
    return half_ring[h][(half_head[h] + half_count[h]) % HALF_SLOTS];
  endfunction

  // applies one operation to the model and returns the result beat it causes
  function automatic fmbq_pkg::out_beat_t queue_op_outcome(input fmbq_pkg::in_beat_t beat);
    fmbq_pkg::out_beat_t o;
    logic [VALUE_W-1:0]  v;
    v = beat.item_value & KEEP_MASK;
    o = '0;
    o.status = fmbq_pkg::STATUS_DONE;
    if (beat.command <= fmbq_pkg::CMD_PUSH_BACK && queue_occupancy() >= CAPACITY) begin
      o.status = fmbq_pkg::STATUS_FULL;
    end else if (beat.command >= fmbq_pkg::CMD_POP_FRONT &&
                 beat.command <= fmbq_pkg::CMD_POP_BACK &&
                 half_count[BACK_HALF] == 0) begin
      // back half empty means the whole queue is empty
      o.result_value = ALL_ONES;
      o.status       = fmbq_pkg::STATUS_EMPTY;
    end else begin
      case (beat.command)
        fmbq_pkg::CMD_PUSH_FRONT: begin
          half_put_first(FRONT_HALF, v);
          if (half_count[FRONT_HALF] > half_count[BACK_HALF]) begin
            half_put_first(BACK_HALF, half_take_last(FRONT_HALF));
          end
        end
        fmbq_pkg::CMD_PUSH_MID: begin
          if (half_count[FRONT_HALF] == half_count[BACK_HALF]) begin
            half_put_first(BACK_HALF, v);
          end else begin
            half_put_last(FRONT_HALF, v);
          end
        end
        fmbq_pkg::CMD_PUSH_BACK: begin
          if (half_count[BACK_HALF] > half_count[FRONT_HALF]) begin
            half_put_last(FRONT_HALF, half_take_first(BACK_HALF));
          end
          half_put_last(BACK_HALF, v);
        end
        fmbq_pkg::CMD_POP_FRONT: begin
          if (half_count[FRONT_HALF] == 0) begin
            o.result_value = half_take_first(BACK_HALF);
          end else begin
            o.result_value = half_take_first(FRONT_HALF);
            if (half_count[BACK_HALF] > half_count[FRONT_HALF] + 1) begin
              half_put_last(FRONT_HALF, half_take_first(BACK_HALF));
            end
          end
        end
        fmbq_pkg::CMD_POP_MID: begin
          if (half_count[FRONT_HALF] == half_count[BACK_HALF]) begin
            o.result_value = half_take_last(FRONT_HALF);
          end else begin
            o.result_value = half_take_first(BACK_HALF);
          end
        end
        fmbq_pkg::CMD_POP_BACK: begin
          o.result_value = half_take_last(BACK_HALF);
          if (half_count[BACK_HALF] < half_count[FRONT_HALF]) begin
            half_put_first(BACK_HALF, half_take_last(FRONT_HALF));
          end
        end
        default: ;  // spare codes leave the queue untouched
      endcase
    end
    o.occupancy = OCC_W'(queue_occupancy());
    return o;
  endfunction

  // push_pct sets the share of pushes among decoded commands
  function automatic fmbq_pkg::in_beat_t random_beat(int unsigned push_pct);
    fmbq_pkg::in_beat_t b;
    if ($urandom_range(99) < 3) begin
      b.command = $urandom_range(1) ? CMD_SPARE_A : CMD_SPARE_B;
    end else if ($urandom_range(99) < push_pct) begin
      b.command = CMD_W'(fmbq_pkg::CMD_PUSH_FRONT) + CMD_W'($urandom_range(2));
    end else begin
      b.command = CMD_W'(fmbq_pkg::CMD_POP_FRONT) + CMD_W'($urandom_range(2));
    end
    case ($urandom_range(7))
      0:       b.item_value = 32'h7FFF_FFFF;
      1:       b.item_value = 32'h8000_0000;
      2:       b.item_value = ALL_ONES;
      3:       b.item_value = '0;
      default: b.item_value = $urandom;
    endcase
    return b;
  endfunction

  // ---------------------------------------------------------------------------
  // sender: one beat per call, entered and left at a falling edge
  // ---------------------------------------------------------------------------
  task automatic offer_op(input fmbq_pkg::in_beat_t beat, input bit typed,
                          input fmbq_pkg::out_beat_t literal);
    fmbq_pkg::out_beat_t predicted;
    in_valid <= 1'b1;
    in_beat  <= beat;
    do @(posedge clk); while (in_stall);
    // the model is advanced even when the row carries its own expectation
    predicted = queue_op_outcome(beat);
    awaited_outcomes.insert(awaited_outcomes.size(), typed ? literal : predicted);
    beats_accepted++;
    @(negedge clk);
    if (burst_left > 0) burst_left--;
    // no gaps while the receiver holds off, so the block backs up
    if (burst_left == 0 && !holding_off) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(12, 1)) @(negedge clk);
      burst_left = ($urandom_range(7) == 0) ? 150 : $urandom_range(30, 1);
    end
  endtask

  // ---------------------------------------------------------------------------
  // receiver: stall patterns in stretches, plus one long hold-off
  // ---------------------------------------------------------------------------
  initial begin : receiver_pacing
    flow_e       flow;
    int unsigned stretch;
    int unsigned tick;
    bit          held;
    tick = 0;
    held = 1'b0;
    @(posedge rst_n);
    forever begin
      flow    = flow_e'($urandom_range(3));
      stretch = $urandom_range(80, 10);
      repeat (stretch) begin
        @(negedge clk);
        tick++;
        if (!held && beats_accepted >= HOLD_OFF_AT) begin
          held        = 1'b1;
          holding_off = 1'b1;
          out_stall  <= 1'b1;
          repeat (HOLD_OFF_CYCLES) @(negedge clk);
          holding_off = 1'b0;
        end
        case (flow)
          FLOW_OPEN:     out_stall <= 1'b0;
          FLOW_COIN:     out_stall <= $urandom_range(1);
          FLOW_PERIODIC: out_stall <= (tick % 4 == 0);
          default:       out_stall <= ($urandom_range(9) < 8);
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // result check against the oldest expectation
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : result_check
    fmbq_pkg::out_beat_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (awaited_outcomes.size() == 0) begin
        $error("unexpected result beat: result_value %0d status %0d occupancy %0d",
               out_beat.result_value, out_beat.status, out_beat.occupancy);
        fail_count++;
      end else begin
        want = awaited_outcomes[0];
        awaited_outcomes.delete(0);
        if (out_beat.result_value !== want.result_value) begin
          $error("result_value: expected %0d, got %0d", want.result_value,
                 out_beat.result_value);
          fail_count++;
        end
        if (out_beat.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_beat.status);
          fail_count++;
        end
        if (out_beat.occupancy !== want.occupancy) begin
          $error("occupancy: expected %0d, got %0d", want.occupancy, out_beat.occupancy);
          fail_count++;
        end
      end
    end
  end

  // watchdog: any beat on either side counts as progress
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == QUIET_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    script_row_t         script [SCRIPT_ROWS];
    fmbq_pkg::in_beat_t  beat;
    fmbq_pkg::out_beat_t want;

    // empty pops, spare codes, extreme values, then pops from a short queue
    script = '{
      '{fmbq_pkg::CMD_POP_FRONT,  32'h0000_0000, 1'b1, ALL_ONES, fmbq_pkg::STATUS_EMPTY, 0},
      '{fmbq_pkg::CMD_POP_MID,    32'h0000_1234, 1'b1, ALL_ONES, fmbq_pkg::STATUS_EMPTY, 0},
      '{fmbq_pkg::CMD_POP_BACK,   ALL_ONES,      1'b1, ALL_ONES, fmbq_pkg::STATUS_EMPTY, 0},
      '{CMD_SPARE_A,              32'hDEAD_BEEF, 1'b1, '0,       fmbq_pkg::STATUS_DONE,  0},
      '{CMD_SPARE_B,              32'h0000_0000, 1'b1, '0,       fmbq_pkg::STATUS_DONE,  0},
      '{fmbq_pkg::CMD_PUSH_BACK,  32'h7FFF_FFFF, 1'b1, '0,       fmbq_pkg::STATUS_DONE,  1},
      '{fmbq_pkg::CMD_PUSH_FRONT, 32'h8000_0000, 1'b1, '0,       fmbq_pkg::STATUS_DONE,  2},
      '{fmbq_pkg::CMD_PUSH_MID,   ALL_ONES,      1'b1, '0,       fmbq_pkg::STATUS_DONE,  3},
      '{fmbq_pkg::CMD_PUSH_MID,   32'h0000_0000, 1'b1, '0,       fmbq_pkg::STATUS_DONE,  4},
      '{fmbq_pkg::CMD_PUSH_BACK,  32'h0000_0001, 1'b1, '0,       fmbq_pkg::STATUS_DONE,  5},
      '{fmbq_pkg::CMD_PUSH_FRONT, 32'hAAAA_AAAA, 1'b1, '0,       fmbq_pkg::STATUS_DONE,  6},
      '{fmbq_pkg::CMD_PUSH_MID,   32'h5555_5555, 1'b1, '0,       fmbq_pkg::STATUS_DONE,  7},
      '{fmbq_pkg::CMD_POP_MID,    32'h0000_0000, 1'b0, '0,       fmbq_pkg::STATUS_DONE,  0},
      '{fmbq_pkg::CMD_POP_MID,    ALL_ONES,      1'b0, '0,       fmbq_pkg::STATUS_DONE,  0},
      '{fmbq_pkg::CMD_POP_FRONT,  32'h0000_0000, 1'b0, '0,       fmbq_pkg::STATUS_DONE,  0},
      '{fmbq_pkg::CMD_POP_BACK,   32'h0000_0000, 1'b0, '0,       fmbq_pkg::STATUS_DONE,  0},
      '{CMD_SPARE_B,              ALL_ONES,      1'b1, '0,       fmbq_pkg::STATUS_DONE,  3},
      '{fmbq_pkg::CMD_POP_FRONT,  32'h0000_0000, 1'b0, '0,       fmbq_pkg::STATUS_DONE,  0},
      '{fmbq_pkg::CMD_POP_BACK,   32'h0000_0000, 1'b0, '0,       fmbq_pkg::STATUS_DONE,  0},
      '{fmbq_pkg::CMD_POP_MID,    32'h0000_0000, 1'b0, '0,       fmbq_pkg::STATUS_DONE,  0},
      '{fmbq_pkg::CMD_POP_MID,    32'h0000_0000, 1'b1, ALL_ONES, fmbq_pkg::STATUS_EMPTY, 0},
      '{fmbq_pkg::CMD_PUSH_MID,   32'h0F0F_0F0F, 1'b1, '0,       fmbq_pkg::STATUS_DONE,  1},
      '{fmbq_pkg::CMD_POP_BACK,   32'h0000_0000, 1'b0, '0,       fmbq_pkg::STATUS_DONE,  0}
    };

    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (script[i]) begin
      beat.command      = script[i].command;
      beat.item_value   = script[i].value;
      want.result_value = script[i].want_value;
      want.status       = script[i].want_status;
      want.occupancy    = OCC_W'(script[i].want_occ);
      offer_op(beat, script[i].typed, want);
    end

    // mixed traffic around a small occupancy
    repeat (100) offer_op(random_beat(55), 1'b0, '0);
    // fill to capacity, then keep pushing into the full queue
    while (queue_occupancy() < CAPACITY) offer_op(random_beat(98), 1'b0, '0);
    repeat (20) offer_op(random_beat(90), 1'b0, '0);
    // drain past empty
    while (queue_occupancy() != 0) offer_op(random_beat(2), 1'b0, '0);
    repeat (20) offer_op(random_beat(10), 1'b0, '0);
    repeat (50) offer_op(random_beat(50), 1'b0, '0);

    in_valid <= 1'b0;
    while (awaited_outcomes.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (fail_count == 0 && awaited_outcomes.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

[files.f]
rtl/fmbq_pkg.sv
rtl/fmbq_ram.sv
rtl/front_middle_back_queue_unit.sv
tb/front_middle_back_queue_unit_test.sv
